[hw/rtl/integer_alu_with_prime_search_core_defines.svh]
// Assertion macros for the integer ALU and prime search controller.
`ifndef INTEGER_ALU_WITH_PRIME_SEARCH_CORE_DEFINES_SVH
`define INTEGER_ALU_WITH_PRIME_SEARCH_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clk edge outside reset.
`define IAPS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("iaps: property violated");
// Check that a condition never holds on a rising clk edge outside reset.
`define IAPS_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("iaps: forbidden condition seen");
`else
`define IAPS_ASSERT(name, prop)
`define IAPS_ASSERT_NEVER(name, expr)
`endif
`endif

[hw/rtl/iaps_pkg.sv]
// Package: opcodes, state encoding and controller/datapath link types.
package iaps_pkg;

  // ASCII opcodes
  localparam logic [7:0] OP_ADD   = 8'd43;
  localparam logic [7:0] OP_SUB   = 8'd45;
  localparam logic [7:0] OP_MUL   = 8'd42;
  localparam logic [7:0] OP_DIV   = 8'd47;
  localparam logic [7:0] OP_PRIME = 8'd112;

  localparam logic [31:0] ANSWER_UNKNOWN = 32'hFFFF_FFFF;
  localparam logic [31:0] INT_MIN        = 32'h8000_0000;
  localparam logic [15:0] C_MINUS_ONE    = 16'hFFFF;
  localparam logic [15:0] FIRST_DIVISOR  = 16'd2;
  localparam logic [31:0] FIRST_PRIME    = 32'd2;

  // Controller states, one-hot
  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_EXEC    = 11'b000_0000_0010,
    S_MUL_WB  = 11'b000_0000_0100,
    S_DIV_RUN = 11'b000_0000_1000,
    S_DIV_WB  = 11'b000_0001_0000,
    S_PR_TEST = 11'b000_0010_0000,
    S_PR_SQ   = 11'b000_0100_0000,
    S_PR_CMP  = 11'b000_1000_0000,
    S_PR_DIV  = 11'b001_0000_0000,
    S_PR_REM  = 11'b010_0000_0000,
    S_FIN     = 11'b100_0000_0000
  } state_t;

  // Source of the pending result
  typedef enum logic [2:0] {
    PEND_ALU,
    PEND_PROD,
    PEND_QUOT,
    PEND_CAND,
    PEND_BASE,
    PEND_ZERO_FAULT
  } pend_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      load;
    logic      mul_en;
    logic      mul_sq;
    logic      div_start;
    logic      div_trial;
    logic      div_step;
    logic      cand_init;
    logic      cand_inc;
    logic      d_init;
    logic      d_next;
    logic      found_inc;
    logic      pend_we;
    pend_sel_t pend_sel;
    logic      res_we;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_mul;
    logic op_div;
    logic op_prime;
    logic c_zero;
    logic c_neg;
    logic div_last;
    logic rem_zero;
    logic sq_gt;
    logic cand_ovf;
    logic found_last;
  } status_t;

endpackage

[hw/rtl/iaps_datapath.sv]
// Datapath: operand registers, shared multiplier, shift-subtract divider,
// prime search counters and result registers.
module iaps_datapath
  import iaps_pkg::*;
(
  input  logic               clk,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic        [7:0]  action,
  input  logic signed [31:0] operand_b,
  input  logic signed [15:0] operand_c,
  output logic signed [31:0] answer,
  output logic               fault
);

  // Operand registers
  logic [7:0]  op;
  logic [31:0] b;
  logic [15:0] c;

  // Multiplier output
  logic [31:0] prod;

  // Divider state
  logic [31:0] dq;
  logic [15:0] drem;
  logic [15:0] dden;
  logic [4:0]  dcnt;

  // Prime search state
  logic [31:0] cand;
  logic [15:0] d;
  logic [14:0] found;

  // Pending result
  logic [31:0] pend_ans;
  logic        pend_fault;

  logic [31:0] c_ext;
  logic [31:0] b_abs;
  logic [15:0] c_abs;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [16:0] rem_shift;
  logic [16:0] rem_diff;
  logic        q_bit;
  logic [32:0] b_inc;
  logic [31:0] cand_start;
  logic [31:0] quot;
  logic        div_ovf;
  logic [15:0] found_plus;
  logic [31:0] alu_ans;

  assign c_ext = {{16{c[15]}}, c};
  assign b_abs = b[31] ? (32'd0 - b) : b;
  assign c_abs = c[15] ? (16'd0 - c) : c;

  // Hold operands of the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= action;
      b  <= operand_b;
      c  <= operand_c;
    end
  end

  // Share one multiplier between the multiply op and the divisor square
  assign mul_a = cmd.mul_sq ? {16'd0, d} : b;
  assign mul_b = cmd.mul_sq ? {16'd0, d} : c_ext;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign rem_shift = {drem, dq[31]};
  assign rem_diff  = rem_shift - {1'b0, dden};
  assign q_bit     = ~rem_diff[16];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq   <= cmd.div_trial ? cand : b_abs;
      dden <= cmd.div_trial ? d : c_abs;
      drem <= 16'd0;
      dcnt <= 5'd0;
    end else if (cmd.div_step) begin
      dq   <= {dq[30:0], q_bit};
      drem <= q_bit ? rem_diff[15:0] : rem_shift[15:0];
      dcnt <= dcnt + 5'd1;
    end
  end

  // First candidate is base + 1, raised to 2 since nothing below is prime
  assign b_inc      = {b[31], b} + 33'd1;
  assign cand_start = ($signed(b_inc) < $signed({1'b0, FIRST_PRIME})) ? FIRST_PRIME
                                                                       : b_inc[31:0];

  always_ff @(posedge clk) begin
    if (cmd.cand_init) begin
      cand  <= cand_start;
      found <= 15'd0;
    end else begin
      if (cmd.cand_inc) begin
        cand <= cand + 32'd1;
      end
      if (cmd.found_inc) begin
        found <= found + 15'd1;
      end
    end
  end

  // Trial divisors: 2, then odd numbers from 3
  always_ff @(posedge clk) begin
    if (cmd.d_init) begin
      d <= FIRST_DIVISOR;
    end else if (cmd.d_next) begin
      d <= (d == FIRST_DIVISOR) ? (d + 16'd1) : (d + 16'd2);
    end
  end

  // Signed quotient and pending result values
  assign quot       = (b[31] ^ c[15]) ? (32'd0 - dq) : dq;
  assign div_ovf    = (b == INT_MIN) && (c == C_MINUS_ONE);
  assign found_plus = {1'b0, found} + 16'd1;

  always_comb begin
    unique case (op)
      OP_ADD:  alu_ans = b + c_ext;
      OP_SUB:  alu_ans = b - c_ext;
      default: alu_ans = ANSWER_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_we) begin
      unique case (cmd.pend_sel)
        PEND_ALU: begin
          pend_ans   <= alu_ans;
          pend_fault <= 1'b0;
        end
        PEND_PROD: begin
          pend_ans   <= prod;
          pend_fault <= 1'b0;
        end
        PEND_QUOT: begin
          pend_ans   <= quot;
          pend_fault <= div_ovf;
        end
        PEND_CAND: begin
          pend_ans   <= cand;
          pend_fault <= 1'b0;
        end
        PEND_BASE: begin
          pend_ans   <= b;
          pend_fault <= 1'b0;
        end
        default: begin
          pend_ans   <= 32'd0;
          pend_fault <= 1'b1;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      answer <= pend_ans;
      fault  <= pend_fault;
    end
  end

  // Status to controller
  assign status.op_mul     = (op == OP_MUL);
  assign status.op_div     = (op == OP_DIV);
  assign status.op_prime   = (op == OP_PRIME);
  assign status.c_zero     = (c == 16'd0);
  assign status.c_neg      = c[15];
  assign status.div_last   = (dcnt == 5'd31);
  assign status.rem_zero   = (drem == 16'd0);
  assign status.sq_gt      = (prod > cand);
  assign status.cand_ovf   = cand[31];
  assign status.found_last = (found_plus == c);

endmodule

[hw/rtl/iaps_ctrl.sv]
// Controller: sequences each request through the datapath and owns the handshakes.
`include "integer_alu_with_prime_search_core_defines.svh"

module iaps_ctrl
  import iaps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.pend_sel = PEND_ALU;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (status.op_mul) begin
          cmd.mul_en = 1'b1;
          state_next = S_MUL_WB;
        end else if (status.op_div) begin
          if (status.c_zero) begin
            cmd.pend_we  = 1'b1;
            cmd.pend_sel = PEND_ZERO_FAULT;
            state_next   = S_FIN;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV_RUN;
          end
        end else if (status.op_prime) begin
          priority if (status.c_neg) begin
            cmd.pend_we  = 1'b1;
            cmd.pend_sel = PEND_ZERO_FAULT;
            state_next   = S_FIN;
          end else if (status.c_zero) begin
            cmd.pend_we  = 1'b1;
            cmd.pend_sel = PEND_BASE;
            state_next   = S_FIN;
          end else begin
            cmd.cand_init = 1'b1;
            state_next    = S_PR_TEST;
          end
        end else begin
          cmd.pend_we  = 1'b1;
          cmd.pend_sel = PEND_ALU;
          state_next   = S_FIN;
        end
      end
      S_MUL_WB: begin
        cmd.pend_we  = 1'b1;
        cmd.pend_sel = PEND_PROD;
        state_next   = S_FIN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DIV_WB;
        end
      end
      S_DIV_WB: begin
        cmd.pend_we  = 1'b1;
        cmd.pend_sel = PEND_QUOT;
        state_next   = S_FIN;
      end
      S_PR_TEST: begin
        if (status.cand_ovf) begin
          cmd.pend_we  = 1'b1;
          cmd.pend_sel = PEND_ZERO_FAULT;
          state_next   = S_FIN;
        end else begin
          cmd.d_init = 1'b1;
          state_next = S_PR_SQ;
        end
      end
      S_PR_SQ: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sq = 1'b1;
        state_next = S_PR_CMP;
      end
      S_PR_CMP: begin
        if (status.sq_gt) begin
          // No divisor up to the root: candidate is prime
          if (status.found_last) begin
            cmd.pend_we  = 1'b1;
            cmd.pend_sel = PEND_CAND;
            state_next   = S_FIN;
          end else begin
            cmd.found_inc = 1'b1;
            cmd.cand_inc  = 1'b1;
            state_next    = S_PR_TEST;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_trial = 1'b1;
          state_next    = S_PR_DIV;
        end
      end
      S_PR_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_PR_REM;
        end
      end
      S_PR_REM: begin
        if (status.rem_zero) begin
          // Composite: drop it and advance
          cmd.cand_inc = 1'b1;
          state_next   = S_PR_TEST;
        end else begin
          cmd.d_next = 1'b1;
          state_next = S_PR_SQ;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.res_we = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_we) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  `IAPS_ASSERT(a_accept_leaves_idle, (req_valid && !req_stall) |=> (state != S_IDLE))
  `IAPS_ASSERT_NEVER(a_no_result_overwrite, cmd.res_we && rsp_valid && rsp_stall)
  `IAPS_ASSERT(a_div_wb_after_run, (state == S_DIV_WB) |-> ($past(state) == S_DIV_RUN))
  `IAPS_ASSERT(a_cmp_after_square, (state == S_PR_CMP) |-> ($past(state) == S_PR_SQ))

endmodule

[hw/rtl/integer_alu_with_prime_search_core.sv]
// Prime search time is data dependent: each divisor tried takes a square, then the
// 32-step shared divider and the remainder check; the search runs until the nth
// prime is found or the candidate passes 2147483647.
// One request is worked at a time; a new word is taken while the last answer waits.
// Reset (rst, synchronous) returns the controller to idle and clears the output valid.
module integer_alu_with_prime_search_core
  import iaps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic        [7:0]  action,
  input  logic signed [31:0] operand_b,
  input  logic signed [15:0] operand_c,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] answer,
  output logic               fault
);

  cmd_t    cmd;
  status_t status;

  iaps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  iaps_datapath u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .status    (status),
    .action    (action),
    .operand_b (operand_b),
    .operand_c (operand_c),
    .answer    (answer),
    .fault     (fault)
  );

endmodule
